>>> src/sin_pkg.sv
`timescale 1ns / 1ps
// sin_pkg: shared constants and types for the skin influence normalizer
// no dependencies

package sin_pkg;

    localparam int JOINT_BITS = 16;
    localparam int LANES      = 4;
    localparam int CFG_BITS   = 16;
    localparam int STRIDE_BITS = 3;
    localparam int COUNT_BITS = 3;
    localparam int IDX_BITS   = 3;

    localparam logic [JOINT_BITS-1:0] UNUSED_JOINT = 16'hFFFF;

    localparam logic [IDX_BITS-1:0] REG_JOINT_SLOTS    = 3'd0;
    localparam logic [IDX_BITS-1:0] REG_WEIGHT_SLOTS   = 3'd1;
    localparam logic [IDX_BITS-1:0] REG_JOINT_LIMIT    = 3'd2;
    localparam logic [IDX_BITS-1:0] REG_ZERO_TOLERANCE = 3'd3;

    typedef struct packed {
        logic [STRIDE_BITS-1:0] joint_slots;
        logic [STRIDE_BITS-1:0] weight_slots;
        logic [CFG_BITS-1:0]    joint_limit;
        logic [CFG_BITS-1:0]    zero_tolerance;
    } cfg_t;

endpackage

>>> src/sin_filter.sv
`timescale 1ns / 1ps
// sin_filter: stride fill and tolerance/joint-limit clearing, one register stage
// depends on sin_pkg

module sin_filter #(
    parameter int WEIGHT_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  sin_pkg::cfg_t                       cfg,
    input  logic                                valid_in,
    input  logic [sin_pkg::JOINT_BITS-1:0]      joint_in [0:sin_pkg::LANES-1],
    input  logic [WEIGHT_BITS-1:0]              weight_in [0:sin_pkg::LANES-1],
    output logic                                valid_out,
    output logic [sin_pkg::JOINT_BITS-1:0]      joint_out [0:sin_pkg::LANES-1],
    output logic [WEIGHT_BITS-1:0]              weight_out [0:sin_pkg::LANES-1],
    output logic [sin_pkg::COUNT_BITS-1:0]      used_out
);

    localparam int CW = (WEIGHT_BITS > sin_pkg::CFG_BITS) ? WEIGHT_BITS : sin_pkg::CFG_BITS;

    logic                               valid_reg;
    logic [sin_pkg::JOINT_BITS-1:0]     joint_reg [0:sin_pkg::LANES-1];
    logic [WEIGHT_BITS-1:0]             weight_reg [0:sin_pkg::LANES-1];
    logic [sin_pkg::COUNT_BITS-1:0]     used_reg;
    logic [sin_pkg::JOINT_BITS-1:0]     joint_next [0:sin_pkg::LANES-1];
    logic [WEIGHT_BITS-1:0]             weight_next [0:sin_pkg::LANES-1];
    logic [sin_pkg::COUNT_BITS-1:0]     used_next;

    always_comb
    begin
        logic [sin_pkg::JOINT_BITS-1:0] j;
        logic [WEIGHT_BITS-1:0]         w;
        used_next = '0;
        for (int i = 0; i < sin_pkg::LANES; i++)
        begin
            j = (sin_pkg::STRIDE_BITS'(i) < cfg.joint_slots) ? joint_in[i]
                                                               : sin_pkg::UNUSED_JOINT;
            w = (sin_pkg::STRIDE_BITS'(i) < cfg.weight_slots) ? weight_in[i] : '0;
            if ((CW'(w) <= CW'(cfg.zero_tolerance)) || (j >= cfg.joint_limit))
            begin
                joint_next[i]  = sin_pkg::UNUSED_JOINT;
                weight_next[i] = '0;
            end
            else
            begin
                joint_next[i]  = j;
                weight_next[i] = w;
                used_next      = used_next + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        joint_reg  <= joint_next;
        weight_reg <= weight_next;
        used_reg   <= used_next;
    end

    assign valid_out  = valid_reg;
    assign joint_out  = joint_reg;
    assign weight_out = weight_reg;
    assign used_out   = used_reg;

endmodule

>>> src/sin_sort.sv
`timescale 1ns / 1ps
// sin_sort: five-compare sorting network over two register stages, plus weight total
// depends on sin_pkg

module sin_sort #(
    parameter int WEIGHT_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                valid_in,
    input  logic [sin_pkg::JOINT_BITS-1:0]      joint_in [0:sin_pkg::LANES-1],
    input  logic [WEIGHT_BITS-1:0]              weight_in [0:sin_pkg::LANES-1],
    input  logic [sin_pkg::COUNT_BITS-1:0]      used_in,
    output logic                                valid_out,
    output logic [sin_pkg::JOINT_BITS-1:0]      joint_out [0:sin_pkg::LANES-1],
    output logic [WEIGHT_BITS-1:0]              weight_out [0:sin_pkg::LANES-1],
    output logic [WEIGHT_BITS+1:0]              total_out,
    output logic [sin_pkg::COUNT_BITS-1:0]      used_out
);

    localparam int TW = WEIGHT_BITS + 2;

    logic                               a_valid_reg, b_valid_reg;
    logic [sin_pkg::JOINT_BITS-1:0]     a_joint_reg [0:sin_pkg::LANES-1];
    logic [WEIGHT_BITS-1:0]             a_weight_reg [0:sin_pkg::LANES-1];
    logic [TW-1:0]                      a_total_reg, b_total_reg;
    logic [sin_pkg::COUNT_BITS-1:0]     a_used_reg, b_used_reg;
    logic [sin_pkg::JOINT_BITS-1:0]     b_joint_reg [0:sin_pkg::LANES-1];
    logic [WEIGHT_BITS-1:0]             b_weight_reg [0:sin_pkg::LANES-1];
    logic [sin_pkg::JOINT_BITS-1:0]     a_joint_next [0:sin_pkg::LANES-1];
    logic [WEIGHT_BITS-1:0]             a_weight_next [0:sin_pkg::LANES-1];
    logic [sin_pkg::JOINT_BITS-1:0]     b_joint_next [0:sin_pkg::LANES-1];
    logic [WEIGHT_BITS-1:0]             b_weight_next [0:sin_pkg::LANES-1];
    logic [TW-1:0]                      a_total_next;

    // first layer: (0,1) (2,3)
    always_comb
    begin
        a_joint_next  = joint_in;
        a_weight_next = weight_in;
        for (int p = 0; p < 2; p++)
        begin
            if (weight_in[2*p] < weight_in[2*p+1])
            begin
                a_weight_next[2*p]   = weight_in[2*p+1];
                a_weight_next[2*p+1] = weight_in[2*p];
                a_joint_next[2*p]    = joint_in[2*p+1];
                a_joint_next[2*p+1]  = joint_in[2*p];
            end
        end
        a_total_next = TW'(weight_in[0]) + TW'(weight_in[1])
                     + TW'(weight_in[2]) + TW'(weight_in[3]);
    end

    // second and third layers: (0,2) (1,3) then (1,2)
    always_comb
    begin
        logic [sin_pkg::JOINT_BITS-1:0] tj;
        logic [WEIGHT_BITS-1:0]         tw;
        tj = '0;
        tw = '0;
        b_joint_next  = a_joint_reg;
        b_weight_next = a_weight_reg;
        for (int p = 0; p < 2; p++)
        begin
            if (b_weight_next[p] < b_weight_next[p+2])
            begin
                tw = b_weight_next[p];
                b_weight_next[p]   = b_weight_next[p+2];
                b_weight_next[p+2] = tw;
                tj = b_joint_next[p];
                b_joint_next[p]    = b_joint_next[p+2];
                b_joint_next[p+2]  = tj;
            end
        end
        if (b_weight_next[1] < b_weight_next[2])
        begin
            tw = b_weight_next[1];
            b_weight_next[1] = b_weight_next[2];
            b_weight_next[2] = tw;
            tj = b_joint_next[1];
            b_joint_next[1]  = b_joint_next[2];
            b_joint_next[2]  = tj;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= valid_in;
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a_joint_reg  <= a_joint_next;
        a_weight_reg <= a_weight_next;
        a_total_reg  <= a_total_next;
        a_used_reg   <= used_in;
        b_joint_reg  <= b_joint_next;
        b_weight_reg <= b_weight_next;
        b_total_reg  <= a_total_reg;
        b_used_reg   <= a_used_reg;
    end

    assign valid_out  = b_valid_reg;
    assign joint_out  = b_joint_reg;
    assign weight_out = b_weight_reg;
    assign total_out  = b_total_reg;
    assign used_out   = b_used_reg;

endmodule

>>> src/sin_divider.sv
`timescale 1ns / 1ps
// sin_divider: pipelined restoring divider, one quotient bit per stage, four lanes
// computes (w * ONE + total / 2) / total; depends on sin_pkg

module sin_divider #(
    parameter int WEIGHT_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                valid_in,
    input  logic [sin_pkg::JOINT_BITS-1:0]      joint_in [0:sin_pkg::LANES-1],
    input  logic [WEIGHT_BITS-1:0]              weight_in [0:sin_pkg::LANES-1],
    input  logic [WEIGHT_BITS+1:0]              total_in,
    input  logic [sin_pkg::COUNT_BITS-1:0]      used_in,
    output logic                                valid_out,
    output logic [sin_pkg::JOINT_BITS-1:0]      joint_out [0:sin_pkg::LANES-1],
    output logic [WEIGHT_BITS-1:0]              weight_out [0:sin_pkg::LANES-1],
    output logic [WEIGHT_BITS-1:0]              quot_out [0:sin_pkg::LANES-1],
    output logic [WEIGHT_BITS+1:0]              total_out,
    output logic [sin_pkg::COUNT_BITS-1:0]      used_out
);

    localparam int W  = WEIGHT_BITS;
    localparam int TW = W + 2;
    localparam int NW = 2 * W;
    localparam int L  = sin_pkg::LANES;

    logic                           valid_reg [0:W];
    logic [sin_pkg::JOINT_BITS-1:0] joint_reg [0:W][0:L-1];
    logic [W-1:0]                   weight_reg [0:W][0:L-1];
    logic [TW-1:0]                  total_reg [0:W];
    logic [sin_pkg::COUNT_BITS-1:0] used_reg [0:W];
    logic [TW-1:0]                  rem_reg [0:W][0:L-1];
    logic [W-1:0]                   low_reg [0:W][0:L-1];
    logic [W-1:0]                   quot_reg [0:W][0:L-1];
    logic [NW-1:0]                  num_next [0:L-1];

    always_comb
    begin
        for (int l = 0; l < L; l++)
            num_next[l] = (NW'(weight_in[l]) << (W - 1)) + NW'(total_in >> 1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg[0] <= 1'b0;
        else
            valid_reg[0] <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        total_reg[0] <= total_in;
        used_reg[0]  <= used_in;
        for (int l = 0; l < L; l++)
        begin
            joint_reg[0][l]  <= joint_in[l];
            weight_reg[0][l] <= weight_in[l];
            rem_reg[0][l]    <= TW'(num_next[l][NW-1:W]);
            low_reg[0][l]    <= num_next[l][W-1:0];
            quot_reg[0][l]   <= '0;
        end
    end

    for (genvar s = 0; s < W; s++)
    begin : g_stage
        logic [TW:0]   trial [0:L-1];
        logic [TW-1:0] rem_next [0:L-1];
        logic          bit_next [0:L-1];

        always_comb
        begin
            for (int l = 0; l < L; l++)
            begin
                trial[l] = {rem_reg[s][l], low_reg[s][l][W-1]};
                if (trial[l] >= (TW+1)'(total_reg[s]))
                begin
                    rem_next[l] = TW'(trial[l] - (TW+1)'(total_reg[s]));
                    bit_next[l] = 1'b1;
                end
                else
                begin
                    rem_next[l] = TW'(trial[l]);
                    bit_next[l] = 1'b0;
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[s+1] <= 1'b0;
            else
                valid_reg[s+1] <= valid_reg[s];
        end

        always_ff @(posedge clk)
        begin
            total_reg[s+1] <= total_reg[s];
            used_reg[s+1]  <= used_reg[s];
            for (int l = 0; l < L; l++)
            begin
                joint_reg[s+1][l]  <= joint_reg[s][l];
                weight_reg[s+1][l] <= weight_reg[s][l];
                rem_reg[s+1][l]    <= rem_next[l];
                low_reg[s+1][l]    <= low_reg[s][l] << 1;
                quot_reg[s+1][l]   <= {quot_reg[s][l][W-2:0], bit_next[l]};
            end
        end
    end

    assign valid_out  = valid_reg[W];
    assign joint_out  = joint_reg[W];
    assign weight_out = weight_reg[W];
    assign quot_out   = quot_reg[W];
    assign total_out  = total_reg[W];
    assign used_out   = used_reg[W];

endmodule

>>> src/skin_influence_normalize.sv
`timescale 1ns / 1ps
// skin_influence_normalize: four-influence skinning weight filter, sort and normalize
// start passes the filter, sort, divider and output registers to done; one vertex accepted every cycle
// the divider produces one quotient bit per stage; busy is always low
// done is a one-cycle strobe and the receiver cannot hold results off
// reset clears all valid bits and loads the register defaults; depends on sin_pkg

module skin_influence_normalize #(
    parameter int WEIGHT_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [sin_pkg::IDX_BITS-1:0]        cfg_index,
    input  logic [sin_pkg::CFG_BITS-1:0]        cfg_data,
    input  logic [sin_pkg::JOINT_BITS-1:0]      joint_a,
    input  logic [sin_pkg::JOINT_BITS-1:0]      joint_b,
    input  logic [sin_pkg::JOINT_BITS-1:0]      joint_c,
    input  logic [sin_pkg::JOINT_BITS-1:0]      joint_d,
    input  logic [WEIGHT_BITS-1:0]              weight_a,
    input  logic [WEIGHT_BITS-1:0]              weight_b,
    input  logic [WEIGHT_BITS-1:0]              weight_c,
    input  logic [WEIGHT_BITS-1:0]              weight_d,
    output logic                                done,
    output logic [sin_pkg::JOINT_BITS-1:0]      sorted_joint_0,
    output logic [sin_pkg::JOINT_BITS-1:0]      sorted_joint_1,
    output logic [sin_pkg::JOINT_BITS-1:0]      sorted_joint_2,
    output logic [sin_pkg::JOINT_BITS-1:0]      sorted_joint_3,
    output logic [WEIGHT_BITS-1:0]              norm_weight_0,
    output logic [WEIGHT_BITS-1:0]              norm_weight_1,
    output logic [WEIGHT_BITS-1:0]              norm_weight_2,
    output logic [WEIGHT_BITS-1:0]              norm_weight_3,
    output logic [sin_pkg::COUNT_BITS-1:0]      used_count
);

    localparam int L = sin_pkg::LANES;
    localparam logic [WEIGHT_BITS-1:0] ONE = WEIGHT_BITS'(1) << (WEIGHT_BITS - 1);

    sin_pkg::cfg_t cfg_reg;

    logic [sin_pkg::JOINT_BITS-1:0] in_joint [0:L-1];
    logic [WEIGHT_BITS-1:0]         in_weight [0:L-1];

    logic                           f_valid, s_valid, d_valid;
    logic [sin_pkg::JOINT_BITS-1:0] f_joint [0:L-1];
    logic [WEIGHT_BITS-1:0]         f_weight [0:L-1];
    logic [sin_pkg::COUNT_BITS-1:0] f_used, s_used, d_used;
    logic [sin_pkg::JOINT_BITS-1:0] s_joint [0:L-1];
    logic [WEIGHT_BITS-1:0]         s_weight [0:L-1];
    logic [WEIGHT_BITS+1:0]         s_total, d_total;
    logic [sin_pkg::JOINT_BITS-1:0] d_joint [0:L-1];
    logic [WEIGHT_BITS-1:0]         d_weight [0:L-1];
    logic [WEIGHT_BITS-1:0]         d_quot [0:L-1];

    logic                           done_reg;
    logic [sin_pkg::JOINT_BITS-1:0] joint_reg [0:L-1];
    logic [WEIGHT_BITS-1:0]         weight_reg [0:L-1];
    logic [WEIGHT_BITS-1:0]         weight_next [0:L-1];
    logic [sin_pkg::COUNT_BITS-1:0] used_reg;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.joint_slots    <= sin_pkg::STRIDE_BITS'(4);
            cfg_reg.weight_slots   <= sin_pkg::STRIDE_BITS'(4);
            cfg_reg.joint_limit    <= sin_pkg::CFG_BITS'(65535);
            cfg_reg.zero_tolerance <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                sin_pkg::REG_JOINT_SLOTS:
                    cfg_reg.joint_slots <= cfg_data[sin_pkg::STRIDE_BITS-1:0];
                sin_pkg::REG_WEIGHT_SLOTS:
                    cfg_reg.weight_slots <= cfg_data[sin_pkg::STRIDE_BITS-1:0];
                sin_pkg::REG_JOINT_LIMIT:
                    cfg_reg.joint_limit <= cfg_data;
                sin_pkg::REG_ZERO_TOLERANCE:
                    cfg_reg.zero_tolerance <= cfg_data;
                default:
                    ;
            endcase
        end
    end

    assign in_joint[0]  = joint_a;
    assign in_joint[1]  = joint_b;
    assign in_joint[2]  = joint_c;
    assign in_joint[3]  = joint_d;
    assign in_weight[0] = weight_a;
    assign in_weight[1] = weight_b;
    assign in_weight[2] = weight_c;
    assign in_weight[3] = weight_d;

    sin_filter #(.WEIGHT_BITS(WEIGHT_BITS)) u_filter (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .valid_in   (start && !busy),
        .joint_in   (in_joint),
        .weight_in  (in_weight),
        .valid_out  (f_valid),
        .joint_out  (f_joint),
        .weight_out (f_weight),
        .used_out   (f_used)
    );

    sin_sort #(.WEIGHT_BITS(WEIGHT_BITS)) u_sort (
        .clk        (clk),
        .rst_n      (rst_n),
        .valid_in   (f_valid),
        .joint_in   (f_joint),
        .weight_in  (f_weight),
        .used_in    (f_used),
        .valid_out  (s_valid),
        .joint_out  (s_joint),
        .weight_out (s_weight),
        .total_out  (s_total),
        .used_out   (s_used)
    );

    sin_divider #(.WEIGHT_BITS(WEIGHT_BITS)) u_divider (
        .clk        (clk),
        .rst_n      (rst_n),
        .valid_in   (s_valid),
        .joint_in   (s_joint),
        .weight_in  (s_weight),
        .total_in   (s_total),
        .used_in    (s_used),
        .valid_out  (d_valid),
        .joint_out  (d_joint),
        .weight_out (d_weight),
        .quot_out   (d_quot),
        .total_out  (d_total),
        .used_out   (d_used)
    );

    // unused influences and a zero total keep the weight unscaled
    always_comb
    begin
        for (int l = 0; l < L; l++)
        begin
            if ((d_joint[l] != sin_pkg::UNUSED_JOINT) && (d_total != '0))
                weight_next[l] = (d_quot[l] > ONE) ? ONE : d_quot[l];
            else
                weight_next[l] = d_weight[l];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= d_valid;
    end

    always_ff @(posedge clk)
    begin
        joint_reg  <= d_joint;
        weight_reg <= weight_next;
        used_reg   <= d_used;
    end

    assign done           = done_reg;
    assign sorted_joint_0 = joint_reg[0];
    assign sorted_joint_1 = joint_reg[1];
    assign sorted_joint_2 = joint_reg[2];
    assign sorted_joint_3 = joint_reg[3];
    assign norm_weight_0  = weight_reg[0];
    assign norm_weight_1  = weight_reg[1];
    assign norm_weight_2  = weight_reg[2];
    assign norm_weight_3  = weight_reg[3];
    assign used_count     = used_reg;

endmodule
